>>> hw/rtl/fsc_pkg.sv
// Constants and per-segment coefficient tables for the fixed-point sine/cosine core.
`timescale 1ns / 1ps

package fsc_pkg;

  // Input reduction: angle is biased by 2^31, then reduced mod 36000 = 32 * 1125.
  localparam logic [10:0] RED_DIV     = 11'd1125;
  localparam logic [26:0] RED_RECIP   = 27'd122167958;  // floor(2^37 / 1125)
  localparam logic [15:0] BIAS_RES    = 16'd11648;      // 2^31 mod 36000
  localparam logic [15:0] BIAS_COMP   = 16'd24352;      // 36000 - 11648

  localparam logic [15:0] TURN_Q1     = 16'd9000;
  localparam logic [15:0] TURN_Q2     = 16'd18000;
  localparam logic [15:0] TURN_Q3     = 16'd27000;
  localparam logic [15:0] TURN_FULL   = 16'd36000;

  localparam logic [13:0] SEG_BRK1    = 14'd1500;
  localparam logic [13:0] SEG_BRK2    = 14'd3000;
  localparam logic [13:0] SEG_BRK3    = 14'd4500;
  localparam logic [13:0] SEG_BRK4    = 14'd6000;
  localparam logic [13:0] SEG_MIRROR  = 14'd9000;

  localparam logic signed [15:0] FULL_SCALE = 16'sd10000;

  typedef enum logic [2:0] {
    SEG_0,
    SEG_1,
    SEG_2,
    SEG_3,
    SEG_MIR
  } seg_e;

  // Linear coefficient.
  function automatic logic [11:0] seg_lin_coef(input seg_e seg);
    logic [11:0] c;
    case (seg)
      SEG_0:   c = 12'd1757;
      SEG_1:   c = 12'd187;
      SEG_2:   c = 12'd2078;
      SEG_3:   c = 12'd232;
      SEG_MIR: c = 12'd944;
      default: c = 12'd0;
    endcase
    return c;
  endfunction

  // Square coefficient.
  function automatic logic [7:0] seg_sq_coef(input seg_e seg);
    logic [7:0] c;
    case (seg)
      SEG_0:   c = 8'd196;
      SEG_1:   c = 8'd58;
      SEG_2:   c = 8'd93;
      SEG_3:   c = 8'd12;
      SEG_MIR: c = 8'd146;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [16:0] seg_lin_div(input seg_e seg);
    logic [16:0] d;
    case (seg)
      SEG_0:   d = 17'd1000;
      SEG_1:   d = 17'd100;
      SEG_2:   d = 17'd1000;
      SEG_3:   d = 17'd100;
      SEG_MIR: d = 17'd100000;
      default: d = 17'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / lin divisor)
  function automatic logic [25:0] seg_lin_recip(input seg_e seg);
    logic [25:0] m;
    case (seg)
      SEG_0:   m = 26'd4294967;
      SEG_1:   m = 26'd42949672;
      SEG_2:   m = 26'd4294967;
      SEG_3:   m = 26'd42949672;
      SEG_MIR: m = 26'd42949;
      default: m = 26'd0;
    endcase
    return m;
  endfunction

  function automatic logic [23:0] seg_sq_div(input seg_e seg);
    logic [23:0] d;
    case (seg)
      SEG_0:   d = 24'd10000000;
      SEG_1:   d = 24'd1000000;
      SEG_2:   d = 24'd1000000;
      SEG_3:   d = 24'd100000;
      SEG_MIR: d = 24'd1000000;
      default: d = 24'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / square divisor)
  function automatic logic [15:0] seg_sq_recip(input seg_e seg);
    logic [15:0] m;
    case (seg)
      SEG_0:   m = 16'd429;
      SEG_1:   m = 16'd4294;
      SEG_2:   m = 16'd4294;
      SEG_3:   m = 16'd42949;
      SEG_MIR: m = 16'd4294;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

  function automatic logic signed [15:0] seg_offset(input seg_e seg);
    logic signed [15:0] o;
    case (seg)
      SEG_0:   o = 16'sd0;
      SEG_1:   o = -16'sd88;
      SEG_2:   o = -16'sd397;
      SEG_3:   o = -16'sd940;
      SEG_MIR: o = 16'sd0;
      default: o = 16'sd0;
    endcase
    return o;
  endfunction

endpackage

>>> hw/rtl/fixed_sine_cosine_core.sv
// Pipelined piecewise-quadratic sine/cosine core, angle in hundredths of a degree.
// Throughput: one request per cycle; each stage stalls only when the stage after it is full.
// The constant reciprocal multiplies (mod 36000 and the segment divisions) set the stage count.
// Reset clears the stage valid bits only; the datapath holds no state between requests.
`timescale 1ns / 1ps

module fixed_sine_cosine_core
  import fsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] angle
  input  logic        s_axis_tuser_i,   // [0] opcode (0 sine, 1 cosine)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [14:0] value, [15] zero
);

  localparam int unsigned NSTG = 9;

  logic [NSTG:1] vld_q;
  logic [NSTG:1] adv;

  always_comb begin
    adv[NSTG] = !vld_q[NSTG] || m_axis_tready_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[1];
  assign m_axis_tvalid_o = vld_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= s_axis_tvalid_i;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: bias angle to unsigned, estimate (x >> 5) / 1125
  logic [31:0] x_biased;
  logic [53:0] red_prod;
  logic [16:0] q1_d, q1_q;
  logic [26:0] y1_q;
  logic [4:0]  lo1_q;
  logic        op1_q;

  assign x_biased = {~s_axis_tdata_i[31], s_axis_tdata_i[30:0]};
  assign red_prod = {27'd0, x_biased[31:5]} * {27'd0, RED_RECIP};
  assign q1_d     = red_prod[53:37];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      q1_q  <= q1_d;
      y1_q  <= x_biased[31:5];
      lo1_q <= x_biased[4:0];
      op1_q <= s_axis_tuser_i;
    end
  end

  // Stage 2: remainder mod 1125 with one correction
  logic [27:0] qm2;
  logic [26:0] r2_raw;
  logic [11:0] r2_lo;
  logic [10:0] r2_d, r2_q;
  logic [4:0]  lo2_q;
  logic        op2_q;

  assign qm2    = {11'd0, q1_q} * {17'd0, RED_DIV};
  assign r2_raw = y1_q - qm2[26:0];
  assign r2_lo  = r2_raw[11:0];
  assign r2_d   = (r2_lo >= {1'b0, RED_DIV}) ? 11'(r2_lo - {1'b0, RED_DIV}) : r2_lo[10:0];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      r2_q  <= r2_d;
      lo2_q <= lo1_q;
      op2_q <= op1_q;
    end
  end

  // Stage 3: undo the bias, angle in 0..35999
  logic [15:0] a3_raw;
  logic [15:0] a3_d, a3_q;
  logic        op3_q;

  assign a3_raw = {r2_q, lo2_q};
  assign a3_d   = (a3_raw >= BIAS_RES) ? (a3_raw - BIAS_RES) : (a3_raw + BIAS_COMP);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      a3_q  <= a3_d;
      op3_q <= op2_q;
    end
  end

  // Stage 4: fold into first quadrant
  logic [15:0] t4_wide;
  logic [13:0] t4_q;
  logic        neg4_d, neg4_q;

  always_comb begin
    if (!op3_q) begin
      if (a3_q <= TURN_Q1) begin
        t4_wide = a3_q;               neg4_d = 1'b0;
      end else if (a3_q <= TURN_Q2) begin
        t4_wide = TURN_Q2 - a3_q;     neg4_d = 1'b0;
      end else if (a3_q <= TURN_Q3) begin
        t4_wide = a3_q - TURN_Q2;     neg4_d = 1'b1;
      end else begin
        t4_wide = TURN_FULL - a3_q;   neg4_d = 1'b1;
      end
    end else begin
      if (a3_q <= TURN_Q1) begin
        t4_wide = TURN_Q1 - a3_q;     neg4_d = 1'b0;
      end else if (a3_q <= TURN_Q2) begin
        t4_wide = a3_q - TURN_Q1;     neg4_d = 1'b1;
      end else if (a3_q <= TURN_Q3) begin
        t4_wide = TURN_Q3 - a3_q;     neg4_d = 1'b1;
      end else begin
        t4_wide = a3_q - TURN_Q3;     neg4_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      t4_q   <= t4_wide[13:0];
      neg4_q <= neg4_d;
    end
  end

  // Stage 5: pick segment, form w*w and c1*w
  seg_e        seg5_d, seg5_q;
  logic [13:0] w5;
  logic [27:0] ww5_full;
  logic [25:0] lin5_full;
  logic [26:0] ww5_q;
  logic [23:0] lin5_q;
  logic        neg5_q;

  always_comb begin
    if (t4_q < SEG_BRK1)      seg5_d = SEG_0;
    else if (t4_q < SEG_BRK2) seg5_d = SEG_1;
    else if (t4_q < SEG_BRK3) seg5_d = SEG_2;
    else if (t4_q < SEG_BRK4) seg5_d = SEG_3;
    else                      seg5_d = SEG_MIR;
  end

  assign w5        = (seg5_d == SEG_MIR) ? (SEG_MIRROR - t4_q) : t4_q;
  assign ww5_full  = {14'd0, w5} * {14'd0, w5};
  assign lin5_full = {12'd0, w5} * {14'd0, seg_lin_coef(seg5_d)};

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      seg5_q <= seg5_d;
      ww5_q  <= ww5_full[26:0];
      lin5_q <= lin5_full[23:0];
      neg5_q <= neg4_q;
    end
  end

  // Stage 6: c2*w*w
  logic [34:0] sq6_full;
  logic [30:0] sq6_q;
  logic [23:0] lin6_q;
  seg_e        seg6_q;
  logic        neg6_q;

  assign sq6_full = {8'd0, ww5_q} * {27'd0, seg_sq_coef(seg5_q)};

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      sq6_q  <= sq6_full[30:0];
      lin6_q <= lin5_q;
      seg6_q <= seg5_q;
      neg6_q <= neg5_q;
    end
  end

  // Stage 7: quotient estimates by reciprocal multiply (low by at most one)
  logic [49:0] lq7_prod;
  logic [46:0] sq7_prod;
  logic [13:0] lq7_q;
  logic [12:0] sqq7_q;
  logic [23:0] lin7_q;
  logic [30:0] sq7_q;
  seg_e        seg7_q;
  logic        neg7_q;

  assign lq7_prod = {26'd0, lin6_q} * {24'd0, seg_lin_recip(seg6_q)};
  assign sq7_prod = {16'd0, sq6_q} * {31'd0, seg_sq_recip(seg6_q)};

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      lq7_q  <= lq7_prod[45:32];
      sqq7_q <= sq7_prod[44:32];
      lin7_q <= lin6_q;
      sq7_q  <= sq6_q;
      seg7_q <= seg6_q;
      neg7_q <= neg6_q;
    end
  end

  // Stage 8: remainder check, bump quotient when it reaches the divisor
  logic [16:0] ldiv8;
  logic [23:0] sdiv8;
  logic [30:0] lm8;
  logic [36:0] sm8;
  logic [23:0] lrem8;
  logic [30:0] srem8;
  logic [13:0] lq8_q;
  logic [12:0] sq8_q;
  seg_e        seg8_q;
  logic        neg8_q;

  assign ldiv8 = seg_lin_div(seg7_q);
  assign sdiv8 = seg_sq_div(seg7_q);
  assign lm8   = {17'd0, lq7_q} * {14'd0, ldiv8};
  assign sm8   = {24'd0, sqq7_q} * {13'd0, sdiv8};
  assign lrem8 = lin7_q - lm8[23:0];
  assign srem8 = sq7_q - sm8[30:0];

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      lq8_q  <= (lrem8 >= {7'd0, ldiv8}) ? (lq7_q + 14'd1) : lq7_q;
      sq8_q  <= (srem8 >= {7'd0, sdiv8}) ? (sqq7_q + 13'd1) : sqq7_q;
      seg8_q <= seg7_q;
      neg8_q <= neg7_q;
    end
  end

  // Stage 9: combine terms, apply quadrant sign
  logic signed [15:0] mag9;
  logic signed [15:0] val9;
  logic [14:0]        val9_q;

  always_comb begin
    if (seg8_q == SEG_MIR) begin
      mag9 = FULL_SCALE - $signed({2'b00, lq8_q}) - $signed({3'b000, sq8_q});
    end else begin
      mag9 = $signed({2'b00, lq8_q}) - $signed({3'b000, sq8_q}) + seg_offset(seg8_q);
    end
    val9 = neg8_q ? -mag9 : mag9;
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      val9_q <= val9[14:0];
    end
  end

  assign m_axis_tdata_o = {1'b0, val9_q};

endmodule

>>> bench/fixed_sine_cosine_core_tb.sv
// Self-checking testbench for the piecewise-quadratic sine/cosine core.
`timescale 1ns / 1ps

module fixed_sine_cosine_core_tb;

  localparam bit OP_SINE   = 1'b0;
  localparam bit OP_COSINE = 1'b1;

  localparam int HALF_TURN_DEG = 18000;
  localparam int QUARTER       = 9000;
  localparam int FULL_TURN     = 36000;
  localparam int DRAIN_CYCLES  = 16;     // pipeline is 9 deep
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    bit          op;
    logic [31:0] angle;
    logic [14:0] value;
  } trig_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] angle
  logic        s_tuser;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [14:0] value, [15] zero

  trig_result_t pending_values[$];
  int           mismatch_count  = 0;
  int           error_count     = 0;
  int           hold_off_cycles = 0;
  bit           idle_en         = 1'b1;
  int           cycle_count     = 0;

  fixed_sine_cosine_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk_i = ~clk_i;

  // First-quadrant curve, t in 0..9000; divisions truncate, operands non-negative.
  function automatic longint quadrant_curve(input longint t);
    longint u;
    if (t < 1500) begin
      return 1757 * t / 1000 - 196 * t * t / 10000000;
    end
    if (t < 3000) begin
      return 187 * t / 100 - 58 * t * t / 1000000 - 88;
    end
    if (t < 4500) begin
      return 2078 * t / 1000 - 93 * t * t / 1000000 - 397;
    end
    if (t < 6000) begin
      return 232 * t / 100 - 12 * t * t / 100000 - 940;
    end
    u = QUARTER - t;
    return 10000 - 944 * u / 100000 - 146 * u * u / 1000000;
  endfunction

  function automatic logic [14:0] predict_trig(input bit op, input logic [31:0] angle);
    longint a;
    longint v;
    a = longint'($signed(angle)) % FULL_TURN;
    if (a < 0) begin
      a += FULL_TURN;
    end
    if (op == OP_SINE) begin
      if (a <= QUARTER) v = quadrant_curve(a);
      else if (a <= HALF_TURN_DEG) v = quadrant_curve(HALF_TURN_DEG - a);
      else if (a <= 3 * QUARTER) v = -quadrant_curve(a - HALF_TURN_DEG);
      else v = -quadrant_curve(FULL_TURN - a);
    end else begin
      if (a <= QUARTER) v = quadrant_curve(QUARTER - a);
      else if (a <= HALF_TURN_DEG) v = -quadrant_curve(a - QUARTER);
      else if (a <= 3 * QUARTER) v = -quadrant_curve(3 * QUARTER - a);
      else v = quadrant_curve(a - 3 * QUARTER);
    end
    return v[14:0];
  endfunction

  // Mix of small wrapped angles, segment/quadrant boundaries and full-range values.
  function automatic logic [31:0] pick_angle();
    int sel;
    int brk;
    int a;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return 32'($urandom_range(0, 8 * FULL_TURN) - 4 * FULL_TURN);
    end
    if (sel < 6) begin
      case ($urandom_range(0, 5))
        0:       brk = 0;
        1:       brk = 1500;
        2:       brk = 3000;
        3:       brk = 4500;
        4:       brk = 6000;
        default: brk = QUARTER;
      endcase
      a = $urandom_range(0, 3) * QUARTER;
      a = $urandom_range(0, 1) ? a + brk : a - brk;
      a = a + $urandom_range(0, 4) - 2 + ($urandom_range(0, 100) - 50) * FULL_TURN;
      return 32'(a);
    end
    return $urandom;
  endfunction

  // One request: optional idle burst, then hold valid until accepted.
  task automatic send_angle(input bit op, input logic [31:0] angle);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] angles[12];
    angles = '{32'd0, 32'd1500, 32'd3000, 32'd4500, 32'd6000, 32'd9000, 32'd18000,
               32'd27000, -32'sd100, 32'd2147472000, 32'h7FFF_FFFF, 32'h8000_0000};
    foreach (angles[i]) begin
      send_angle(OP_SINE, angles[i]);
      send_angle(OP_COSINE, angles[i]);
    end
    wait_all_results();
  endtask

  // Receiver stalls long enough for the pipeline to fill and push back.
  task automatic test_backpressure();
    hold_off_cycles = 150;
    repeat (40) send_angle(1'($urandom_range(0, 1)), pick_angle());
    wait_all_results();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_angle(1'($urandom_range(0, 1)), pick_angle());
  endtask

  task automatic test_full_rate(input int count);
    idle_en = 1'b0;
    test_random(count);
    wait_all_results();
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (mismatch_count < 10) begin
      $display("%s", msg);
    end
    mismatch_count++;
  endtask

  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
      end
    end
  end

  // Results are checked before the same-edge request is queued.
  always @(posedge clk_i) begin : track_results
    trig_result_t want;
    trig_result_t req;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_values.size() == 0) begin
        report_error($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = pending_values.pop_front();
        if (m_tdata !== {1'b0, want.value}) begin
          report_error($sformatf("mismatch op=%0d angle=%0d: expected %0d got %0d (raw %h)",
                                 want.op, $signed(want.angle), $signed(want.value),
                                 $signed(m_tdata[14:0]), m_tdata));
        end
      end
    end
    if (rst_ni && s_tvalid && s_tready) begin
      req.op    = s_tuser;
      req.angle = s_tdata;
      req.value = predict_trig(s_tuser, s_tdata);
      pending_values.push_back(req);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random(1500);
    test_full_rate(300);

    if (error_count == 0 && pending_values.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
